// File: hw/rtl/ddws_pkg.sv
package ddws_pkg;

    // command codes
    localparam logic [2:0] FUNC_FORWARD = 3'd0;
    localparam logic [2:0] FUNC_TURN    = 3'd1;
    localparam logic [2:0] FUNC_ARC     = 3'd2;
    localparam logic [2:0] FUNC_HEADING = 3'd3;
    localparam logic [2:0] FUNC_ANGVEL  = 3'd4;
    localparam logic [2:0] FUNC_STOP    = 3'd5;

    // register map index (paddr[2])
    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_TRACK  = 1'b1;

    localparam int RADIUS_W = 17;
    localparam int TRACK_W  = 18;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 17'd3277;
    localparam logic [TRACK_W-1:0]  TRACK_RST  = 18'd13107;

    localparam int FRAC_BITS_DEF = 16;

    // 180/pi in Q.20
    localparam int KDEG_BITS = 20;
    localparam int KDEG_W    = 26;
    localparam logic [KDEG_W-1:0] KDEG = 26'd60078979;

    // wheel linear speed clamp, 2^35
    localparam int QW1 = 36;
    localparam logic [QW1-1:0] V_LIMIT = 36'h8_0000_0000;

    localparam int QW2 = 32;
    localparam int N2W = QW1 + KDEG_W;

    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] left_speed;
        logic [31:0] right_speed;
        logic        arc_fallback;
        logic        saturated;
    } t_result;

endpackage

// File: hw/rtl/ddws_div_cell.sv
module ddws_div_cell #(
    parameter int DW = 8,
    parameter int QW = 8,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_word,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_word,
    output logic [DW-1:0] o_den,
    output logic [SW-1:0] o_side
);

    logic          r_vld;
    logic [DW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_word, n_word;
    logic [DW-1:0] r_den;
    logic [SW-1:0] r_side;
    logic [DW:0]   w_trial;
    logic          w_ge;

    // shift in the next numerator bit, subtract when it fits
    assign w_trial = {i_rem, i_word[QW-1]};
    assign w_ge    = w_trial >= {1'b0, i_den};
    assign n_rem   = w_ge ? DW'(w_trial - {1'b0, i_den}) : w_trial[DW-1:0];
    assign n_word  = {i_word[QW-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_word <= n_word;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_word = r_word;
    assign o_den  = r_den;
    assign o_side = r_side;

endmodule

// File: hw/rtl/ddws_div.sv
module ddws_div #(
    parameter int NW = 62,
    parameter int DW = 21,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_mag,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quot,
    output logic          o_ovf,
    output logic [SW-1:0] o_side
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [CW-1:0] w_hi, w_den_x;
    logic          w_ovf;

    logic          r_vld;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_word;
    logic [DW-1:0] r_den;
    logic [SW:0]   r_side;

    logic          c_vld  [QW+1];
    logic [DW-1:0] c_rem  [QW+1];
    logic [QW-1:0] c_word [QW+1];
    logic [DW-1:0] c_den  [QW+1];
    logic [SW:0]   c_side [QW+1];

    // quotient needs more than QW bits when the top part already reaches the divisor
    assign w_hi    = CW'(i_mag[NW-1:QW]);
    assign w_den_x = CW'(i_den);
    assign w_ovf   = w_hi >= w_den_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_ovf ? '0 : w_hi[DW-1:0];
            r_word <= i_mag[QW-1:0];
            r_den  <= i_den;
            r_side <= {w_ovf, i_side};
        end
    end

    assign c_vld[0]  = r_vld;
    assign c_rem[0]  = r_rem;
    assign c_word[0] = r_word;
    assign c_den[0]  = r_den;
    assign c_side[0] = r_side;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        ddws_div_cell #(
            .DW(DW),
            .QW(QW),
            .SW(SW + 1)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_vld  (c_vld[g]),
            .i_rem  (c_rem[g]),
            .i_word (c_word[g]),
            .i_den  (c_den[g]),
            .i_side (c_side[g]),
            .o_vld  (c_vld[g+1]),
            .o_rem  (c_rem[g+1]),
            .o_word (c_word[g+1]),
            .o_den  (c_den[g+1]),
            .o_side (c_side[g+1])
        );
    end

    assign o_vld  = c_vld[QW];
    assign o_quot = c_word[QW];
    assign o_ovf  = c_side[QW][SW];
    assign o_side = c_side[QW][SW-1:0];

endmodule

// File: hw/rtl/ddws_front.sv
module ddws_front #(
    parameter int FRAC_BITS = ddws_pkg::FRAC_BITS_DEF,
    parameter int N1W = 52,
    parameter int D1W = 21
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [2:0]                  i_func,
    input  logic signed [31:0]          i_speed,
    input  logic signed [31:0]          i_shape_arg,
    input  logic [ddws_pkg::TRACK_W-1:0] i_wheel_track,
    output logic                        o_vld,
    output logic [N1W-1:0]              o_l_mag,
    output logic                        o_l_neg,
    output logic [N1W-1:0]              o_r_mag,
    output logic                        o_r_neg,
    output logic [D1W-1:0]              o_den,
    output logic                        o_fb
);

    localparam logic [32:0] ARC_LO = 33'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [32:0] ARC_HI = 33'(64'd10 << FRAC_BITS);

    // stage 1: operand select and products
    logic [31:0]        w_arg_mag;
    logic               w_in_rng;
    logic [20:0]        w_track5, w_bx;
    logic signed [31:0] w_by;
    logic signed [63:0] w_pa;
    logic signed [53:0] w_pb;

    logic               r_v1;
    logic [2:0]         r_func;
    logic signed [31:0] r_spd;
    logic signed [63:0] r_pa;
    logic signed [53:0] r_pb;
    logic [31:0]        r_arg_mag;
    logic               r_arg_neg;
    logic               r_in_rng;

    assign w_arg_mag = i_shape_arg[31] ? (~i_shape_arg + 32'd1) : i_shape_arg;
    assign w_in_rng  = ({1'b0, w_arg_mag} >= ARC_LO) && ({1'b0, w_arg_mag} <= ARC_HI);
    assign w_track5  = (21'(i_wheel_track) << 2) + 21'(i_wheel_track);
    assign w_bx      = (i_func == ddws_pkg::FUNC_HEADING) ? w_track5 : 21'(i_wheel_track);
    assign w_by      = (i_func == ddws_pkg::FUNC_TURN || i_func == ddws_pkg::FUNC_ARC) ?
                       i_speed : i_shape_arg;
    assign w_pa      = i_speed * i_shape_arg;
    assign w_pb      = $signed({1'b0, w_bx}) * w_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_func    <= i_func;
            r_spd     <= i_speed;
            r_pa      <= w_pa;
            r_pb      <= w_pb;
            r_arg_mag <= w_arg_mag;
            r_arg_neg <= i_shape_arg[31];
            r_in_rng  <= w_in_rng;
        end
    end

    // stage 2: wheel numerators per mode
    logic signed [65:0] w_pa_x, w_pb_x, w_spd_x, w_sum, w_dif, w_d1, w_dh, w_l, w_r;
    logic [D1W-1:0]     w_den;
    logic               w_dneg, w_fb;

    logic               r_v2;
    logic signed [N1W:0] r_l, r_r;
    logic [D1W-1:0]     r_den2;
    logic               r_dneg, r_fb2;

    assign w_pa_x  = 66'(r_pa);
    assign w_pb_x  = 66'(r_pb);
    assign w_spd_x = 66'(r_spd);
    assign w_sum   = (w_pa_x <<< 1) + w_pb_x;
    assign w_dif   = (w_pa_x <<< 1) - w_pb_x;
    assign w_d1    = w_pb_x >>> (FRAC_BITS + 1);
    assign w_dh    = w_pb_x >>> FRAC_BITS;

    always_comb begin
        w_l    = '0;
        w_r    = '0;
        w_den  = D1W'(1);
        w_dneg = 1'b0;
        w_fb   = 1'b0;
        case (r_func)
            ddws_pkg::FUNC_FORWARD: begin
                w_l = w_spd_x;
                w_r = w_spd_x;
            end
            ddws_pkg::FUNC_TURN: begin
                w_l = -w_d1;
                w_r = w_d1;
            end
            ddws_pkg::FUNC_ARC: begin
                if (r_in_rng) begin
                    w_l    = w_dif;
                    w_r    = w_sum;
                    w_den  = D1W'({r_arg_mag, 1'b0});
                    w_dneg = r_arg_neg;
                end else begin
                    w_l  = w_spd_x;
                    w_r  = w_spd_x;
                    w_fb = 1'b1;
                end
            end
            ddws_pkg::FUNC_HEADING: begin
                w_l = w_spd_x - w_dh;
                w_r = w_spd_x + w_dh;
            end
            ddws_pkg::FUNC_ANGVEL: begin
                w_l = w_spd_x - w_d1;
                w_r = w_spd_x + w_d1;
            end
            default: begin
                w_l = '0;
                w_r = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l    <= w_l[N1W:0];
            r_r    <= w_r[N1W:0];
            r_den2 <= w_den;
            r_dneg <= w_dneg;
            r_fb2  <= w_fb;
        end
    end

    // stage 3: sign and magnitude
    logic signed [N1W:0] w_l_abs, w_r_abs;
    logic                r_v3;
    logic [N1W-1:0]      r_lmag, r_rmag;
    logic                r_lneg, r_rneg, r_fb3;
    logic [D1W-1:0]      r_den3;

    assign w_l_abs = r_l[N1W] ? -r_l : r_l;
    assign w_r_abs = r_r[N1W] ? -r_r : r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lmag <= w_l_abs[N1W-1:0];
            r_rmag <= w_r_abs[N1W-1:0];
            r_lneg <= r_l[N1W] ^ r_dneg;
            r_rneg <= r_r[N1W] ^ r_dneg;
            r_den3 <= r_den2;
            r_fb3  <= r_fb2;
        end
    end

    assign o_vld   = r_v3;
    assign o_l_mag = r_lmag;
    assign o_l_neg = r_lneg;
    assign o_r_mag = r_rmag;
    assign o_r_neg = r_rneg;
    assign o_den   = r_den3;
    assign o_fb    = r_fb3;

endmodule

// File: hw/rtl/differential_drive_wheel_speed.sv
// Differential drive wheel speeds: one motion command in, one pair of wheel
// speeds (deg/s, signed Q) out.
// Input channel: i_in_valid / o_in_ready with i_func, i_speed, i_shape_arg.
// Output channel: o_out_valid / i_out_ready with o_left_speed, o_right_speed,
// o_arc_fallback, o_saturated.
// Registers over the APB port: 0x0 wheel radius, 0x4 wheel track. Write them
// only while no command is in flight.
// Throughput: one command per cycle while o_in_ready is high. The path from
// transfer to o_out_valid passes two chains of restoring division cells (36
// cells for the arc quotient, 32 for the radius quotient), each with a prep
// stage, plus three front stages, two scaling stages and the output register.
// A stalled receiver holds the result in the output register; one more
// result lands in a skid register, and only then does o_in_ready drop and
// the whole pipeline hold.
// Reset (synchronous, active low) empties the pipeline and loads the default
// wheel radius and track.
module differential_drive_wheel_speed #(
    parameter int FRAC_BITS = ddws_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_speed,
    input  logic signed [31:0] i_shape_arg,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_left_speed,
    output logic signed [31:0] o_right_speed,
    output logic               o_arc_fallback,
    output logic               o_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int ARC_MAXW = (FRAC_BITS + 5 > 18) ? FRAC_BITS + 5 : 18;
    localparam int N1W      = 34 + ARC_MAXW;
    localparam int D1W      = FRAC_BITS + 5;
    localparam int SH2      = (FRAC_BITS < ddws_pkg::KDEG_BITS) ?
                              ddws_pkg::KDEG_BITS - FRAC_BITS : 0;
    localparam int S2       = (FRAC_BITS > ddws_pkg::KDEG_BITS) ?
                              FRAC_BITS - ddws_pkg::KDEG_BITS : 0;
    localparam int D2W      = ddws_pkg::RADIUS_W + SH2;

    // configuration registers
    logic [ddws_pkg::RADIUS_W-1:0] r_wheel_radius;
    logic [ddws_pkg::TRACK_W-1:0]  r_wheel_track;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_radius <= ddws_pkg::RADIUS_RST;
            r_wheel_track  <= ddws_pkg::TRACK_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                ddws_pkg::REG_RADIUS: r_wheel_radius <= pwdata[ddws_pkg::RADIUS_W-1:0];
                ddws_pkg::REG_TRACK:  r_wheel_track  <= pwdata[ddws_pkg::TRACK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ddws_pkg::REG_RADIUS: prdata = 32'(r_wheel_radius);
            ddws_pkg::REG_TRACK:  prdata = 32'(r_wheel_track);
            default:              prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // pipeline advance
    logic w_en;
    logic r_skid_v;

    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en;

    // front: mode decode and wheel numerators
    logic           w_f_vld, w_f_lneg, w_f_rneg, w_f_fb;
    logic [N1W-1:0] w_f_lmag, w_f_rmag;
    logic [D1W-1:0] w_f_den;

    ddws_front #(
        .FRAC_BITS(FRAC_BITS),
        .N1W      (N1W),
        .D1W      (D1W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_vld        (i_in_valid),
        .i_func       (i_func),
        .i_speed      (i_speed),
        .i_shape_arg  (i_shape_arg),
        .i_wheel_track(r_wheel_track),
        .o_vld        (w_f_vld),
        .o_l_mag      (w_f_lmag),
        .o_l_neg      (w_f_lneg),
        .o_r_mag      (w_f_rmag),
        .o_r_neg      (w_f_rneg),
        .o_den        (w_f_den),
        .o_fb         (w_f_fb)
    );

    // arc quotient (divisor 1 outside arc mode)
    logic                    w_d1l_vld, w_d1r_vld, w_d1l_ovf, w_d1r_ovf;
    logic [ddws_pkg::QW1-1:0] w_d1l_q, w_d1r_q;
    logic [0:0]              w_d1l_side;
    logic [1:0]              w_d1r_side;

    ddws_div #(
        .NW(N1W), .DW(D1W), .QW(ddws_pkg::QW1), .SW(1)
    ) u_div1_l (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_f_vld),
        .i_mag  (w_f_lmag),
        .i_den  (w_f_den),
        .i_side (w_f_lneg),
        .o_vld  (w_d1l_vld),
        .o_quot (w_d1l_q),
        .o_ovf  (w_d1l_ovf),
        .o_side (w_d1l_side)
    );

    ddws_div #(
        .NW(N1W), .DW(D1W), .QW(ddws_pkg::QW1), .SW(2)
    ) u_div1_r (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_f_vld),
        .i_mag  (w_f_rmag),
        .i_den  (w_f_den),
        .i_side ({w_f_fb, w_f_rneg}),
        .o_vld  (w_d1r_vld),
        .o_quot (w_d1r_q),
        .o_ovf  (w_d1r_ovf),
        .o_side (w_d1r_side)
    );

    // clamp linear speed, then scale by 180/pi
    logic                     r_m1_v, r_m1_lneg, r_m1_rneg, r_m1_fb;
    logic [ddws_pkg::QW1-1:0] r_m1_lmag, r_m1_rmag;
    logic                     r_m2_v, r_m2_lneg, r_m2_rneg, r_m2_fb;
    logic [ddws_pkg::N2W-1:0] r_m2_lnum, r_m2_rnum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
        end else if (w_en) begin
            r_m1_v <= w_d1r_vld;
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_lmag <= (w_d1l_ovf || w_d1l_q > ddws_pkg::V_LIMIT) ?
                         ddws_pkg::V_LIMIT : w_d1l_q;
            r_m1_rmag <= (w_d1r_ovf || w_d1r_q > ddws_pkg::V_LIMIT) ?
                         ddws_pkg::V_LIMIT : w_d1r_q;
            r_m1_lneg <= w_d1l_side[0];
            r_m1_rneg <= w_d1r_side[0];
            r_m1_fb   <= w_d1r_side[1];
            r_m2_lnum <= ddws_pkg::N2W'(r_m1_lmag) * ddws_pkg::N2W'(ddws_pkg::KDEG);
            r_m2_rnum <= ddws_pkg::N2W'(r_m1_rmag) * ddws_pkg::N2W'(ddws_pkg::KDEG);
            r_m2_lneg <= r_m1_lneg;
            r_m2_rneg <= r_m1_rneg;
            r_m2_fb   <= r_m1_fb;
        end
    end

    // radius divisor, zero radius counts as one LSB
    logic [ddws_pkg::RADIUS_W-1:0] w_rad_nz;
    logic [D2W-1:0]                w_den2;

    assign w_rad_nz = (r_wheel_radius == '0) ? ddws_pkg::RADIUS_W'(1) : r_wheel_radius;
    assign w_den2   = D2W'(w_rad_nz) << SH2;

    logic                     w_d2l_vld, w_d2r_vld, w_d2l_ovf, w_d2r_ovf;
    logic [ddws_pkg::QW2-1:0] w_d2l_q, w_d2r_q;
    logic [0:0]               w_d2l_side;
    logic [1:0]               w_d2r_side;

    ddws_div #(
        .NW(ddws_pkg::N2W), .DW(D2W), .QW(ddws_pkg::QW2), .SW(1)
    ) u_div2_l (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_m2_v),
        .i_mag  (r_m2_lnum),
        .i_den  (w_den2),
        .i_side (r_m2_lneg),
        .o_vld  (w_d2l_vld),
        .o_quot (w_d2l_q),
        .o_ovf  (w_d2l_ovf),
        .o_side (w_d2l_side)
    );

    ddws_div #(
        .NW(ddws_pkg::N2W), .DW(D2W), .QW(ddws_pkg::QW2), .SW(2)
    ) u_div2_r (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_m2_v),
        .i_mag  (r_m2_rnum),
        .i_den  (w_den2),
        .i_side ({r_m2_fb, r_m2_rneg}),
        .o_vld  (w_d2r_vld),
        .o_quot (w_d2r_q),
        .o_ovf  (w_d2r_ovf),
        .o_side (w_d2r_side)
    );

    // rescale and saturate to 32 bits; returns {clip, value}
    function automatic logic [32:0] f_sat(input logic [35:0] fm, input logic ovf,
                                          input logic neg);
        logic [4:0]  hi;
        logic        clip;
        logic [31:0] val;
        hi   = fm[35:31];
        clip = neg ? (ovf || hi > 5'd1 || (hi == 5'd1 && fm[30:0] != '0))
                   : (ovf || hi != '0);
        if (clip) begin
            val = neg ? ddws_pkg::SAT_MIN : ddws_pkg::SAT_MAX;
        end else begin
            val = neg ? (~fm[31:0] + 32'd1) : fm[31:0];
        end
        return {clip, val};
    endfunction

    logic [32:0]       w_sat_l, w_sat_r;
    ddws_pkg::t_result w_res;

    assign w_sat_l = f_sat(36'(w_d2l_q) << S2, w_d2l_ovf, w_d2l_side[0]);
    assign w_sat_r = f_sat(36'(w_d2r_q) << S2, w_d2r_ovf, w_d2r_side[0]);

    always_comb begin
        w_res.left_speed   = w_sat_l[31:0];
        w_res.right_speed  = w_sat_r[31:0];
        w_res.arc_fallback = w_d2r_side[1];
        w_res.saturated    = w_sat_l[32] | w_sat_r[32];
    end

    // output register and skid register
    logic              r_out_v, n_out_v, n_skid_v;
    ddws_pkg::t_result r_out, n_out, r_skid, n_skid;
    logic              w_take, w_arrive;

    assign w_take   = r_out_v && i_out_ready;
    assign w_arrive = w_en && w_d2r_vld;

    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_skid_v = r_skid_v;
        n_skid   = r_skid;
        if (r_skid_v) begin
            if (w_take) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (w_arrive) begin
            if (!r_out_v || w_take) begin
                n_out   = w_res;
                n_out_v = 1'b1;
            end else begin
                // receiver stalled: park the result
                n_skid   = w_res;
                n_skid_v = 1'b1;
            end
        end else if (w_take) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid    = r_out_v;
    assign o_left_speed   = r_out.left_speed;
    assign o_right_speed  = r_out.right_speed;
    assign o_arc_fallback = r_out.arc_fallback;
    assign o_saturated    = r_out.saturated;

    a_wheels_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_d2l_vld == w_d2r_vld) && (w_d1l_vld == w_d1r_vld))
        else $error("left and right division chains out of step");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a result while output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_out_ready) |=> (r_skid_v && $stable(r_skid)))
        else $error("parked result lost while receiver stalled");

endmodule

// File: test/wheel_speed_checker.sv
module wheel_speed_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_speed,
    input  logic [31:0] i_shape_arg,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] o_left_speed,
    input  logic [31:0] o_right_speed,
    input  logic        o_arc_fallback,
    input  logic        o_saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_fallbacks,
    output int          o_clipped
);

    localparam int FB = ddws_pkg::FRAC_BITS_DEF;

    logic [ddws_pkg::RADIUS_W-1:0] radius_q = ddws_pkg::RADIUS_RST;
    logic [ddws_pkg::TRACK_W-1:0]  track_q  = ddws_pkg::TRACK_RST;
    ddws_pkg::t_result             wheel_q[$];

    initial begin
        o_errors    = 0;
        o_checked   = 0;
        o_fallbacks = 0;
        o_clipped   = 0;
    end

    assign o_pending = wheel_q.size();

    // linear wheel speed to deg/s, before saturation
    function automatic longint wheel_deg(longint v, longint r);
        if (v > longint'(ddws_pkg::V_LIMIT)) v = longint'(ddws_pkg::V_LIMIT);
        if (v < -longint'(ddws_pkg::V_LIMIT)) v = -longint'(ddws_pkg::V_LIMIT);
        return (v * longint'(ddws_pkg::KDEG)) / (r <<< (ddws_pkg::KDEG_BITS - FB));
    endfunction

    function automatic logic [31:0] clip32(longint x, inout logic hit);
        if (x > 64'sd2147483647) begin
            hit = 1'b1;
            return ddws_pkg::SAT_MAX;
        end
        if (x < -64'sd2147483648) begin
            hit = 1'b1;
            return ddws_pkg::SAT_MIN;
        end
        return x[31:0];
    endfunction

    function automatic ddws_pkg::t_result predict_wheels(logic [2:0] func,
                                                         logic signed [31:0] spd,
                                                         logic signed [31:0] arg);
        longint            s, a, t, r, vl, vr, d, mag;
        logic              hit;
        ddws_pkg::t_result res;
        s   = spd;
        a   = arg;
        t   = track_q;
        r   = (radius_q == '0) ? 1 : radius_q;
        vl  = 0;
        vr  = 0;
        hit = 1'b0;
        res.arc_fallback = 1'b0;
        case (func)
            ddws_pkg::FUNC_FORWARD: begin
                vl = s;
                vr = s;
            end
            ddws_pkg::FUNC_TURN: begin
                d  = (s * t) >>> (FB + 1);
                vl = -d;
                vr = d;
            end
            ddws_pkg::FUNC_ARC: begin
                mag = (a < 0) ? -a : a;
                if (mag < ((64'sd1 <<< FB) + 5) / 10 || mag > (64'sd10 <<< FB)) begin
                    res.arc_fallback = 1'b1;
                    vl = s;
                    vr = s;
                end else begin
                    vl = s * (2 * a - t) / (2 * a);
                    vr = s * (2 * a + t) / (2 * a);
                end
            end
            ddws_pkg::FUNC_HEADING: begin
                d  = (5 * t * a) >>> FB;
                vl = s - d;
                vr = s + d;
            end
            ddws_pkg::FUNC_ANGVEL: begin
                d  = (t * a) >>> (FB + 1);
                vl = s - d;
                vr = s + d;
            end
            default: ;
        endcase
        res.left_speed  = clip32(wheel_deg(vl, r), hit);
        res.right_speed = clip32(wheel_deg(vr, r), hit);
        res.saturated   = hit;
        return res;
    endfunction

    always @(posedge i_clk) begin
        ddws_pkg::t_result want;
        if (!i_rst_n) begin
            radius_q <= ddws_pkg::RADIUS_RST;
            track_q  <= ddws_pkg::TRACK_RST;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == ddws_pkg::REG_TRACK)
                    track_q <= pwdata[ddws_pkg::TRACK_W-1:0];
                else
                    radius_q <= pwdata[ddws_pkg::RADIUS_W-1:0];
            end
            if (i_in_valid && o_in_ready)
                wheel_q.push_back(predict_wheels(i_func, i_speed, i_shape_arg));
            if (o_out_valid && i_out_ready) begin
                if (wheel_q.size() == 0) begin
                    $display("%0t: result with nothing expected: left %h right %h",
                             $time, o_left_speed, o_right_speed);
                    o_errors++;
                end else begin
                    want = wheel_q.pop_front();
                    o_checked++;
                    if (want.arc_fallback) o_fallbacks++;
                    if (want.saturated) o_clipped++;
                    if (o_left_speed !== want.left_speed) begin
                        $display("%0t: left_speed expected %h actual %h",
                                 $time, want.left_speed, o_left_speed);
                        o_errors++;
                    end
                    if (o_right_speed !== want.right_speed) begin
                        $display("%0t: right_speed expected %h actual %h",
                                 $time, want.right_speed, o_right_speed);
                        o_errors++;
                    end
                    if (o_arc_fallback !== want.arc_fallback) begin
                        $display("%0t: arc_fallback expected %b actual %b",
                                 $time, want.arc_fallback, o_arc_fallback);
                        o_errors++;
                    end
                    if (o_saturated !== want.saturated) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.saturated, o_saturated);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

// File: test/tb_top.sv
module tb_top;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 100;
    localparam int PER_PHASE   = 175;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [2:0]  i_func      = ddws_pkg::FUNC_STOP;
    logic [31:0] i_speed     = '0;
    logic [31:0] i_shape_arg = '0;
    logic        i_out_ready = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;

    logic        o_in_ready, o_out_valid, o_arc_fallback, o_saturated, pready;
    logic [31:0] o_left_speed, o_right_speed, prdata;

    int errors, pending, checked, fallbacks, clipped;
    int cycles = 0;
    int sent   = 0;
    bit quiet  = 1'b0;

    always #10 i_clk = ~i_clk;

    differential_drive_wheel_speed u_top (.*);

    wheel_speed_checker u_chk (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_func, .i_speed, .i_shape_arg,
        .o_out_valid, .i_out_ready, .o_left_speed, .o_right_speed, .o_arc_fallback,
        .o_saturated, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending), .o_checked(checked),
        .o_fallbacks(fallbacks), .o_clipped(clipped)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stall bursts, none in the quiet phase
    always @(posedge i_clk) begin
        int stall_left, run_left;
        if (quiet) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (run_left > 0) begin
            i_out_ready <= 1'b1;
            run_left--;
        end else if ($urandom_range(0, 1)) begin
            stall_left = $urandom_range(0, 15);
            i_out_ready <= 1'b0;
        end else begin
            run_left = $urandom_range(1, 40);
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_cmd(logic [2:0] func, logic [31:0] spd, logic [31:0] arg);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_speed     <= spd;
        i_shape_arg <= arg;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    // hold off until every result is back, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(logic addr_sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {addr_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_speed();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hffff_ffff;
                endcase
            end
            1, 2: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 19)
                                              : -$urandom_range(0, 1 << 19);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_radius();
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0: mag = $urandom_range(6552, 6555);
            1: mag = $urandom_range(655358, 655362);
            2: return $urandom;
            default: mag = $urandom_range(6554, 655360);
        endcase
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    task automatic send_random();
        logic [2:0] func;
        func = $urandom_range(0, 7);
        case (func)
            ddws_pkg::FUNC_ARC: send_cmd(func, pick_speed(), pick_radius());
            ddws_pkg::FUNC_HEADING, ddws_pkg::FUNC_ANGVEL:
                send_cmd(func, pick_speed(), $urandom_range(0, 3) == 0 ? $urandom
                                             : pick_speed());
            default: send_cmd(func, pick_speed(), $urandom);
        endcase
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners at reset geometry
        send_cmd(ddws_pkg::FUNC_FORWARD, 32'h7fff_ffff, 32'h0);
        send_cmd(ddws_pkg::FUNC_FORWARD, 32'h8000_0000, 32'hffff_ffff);
        send_cmd(ddws_pkg::FUNC_FORWARD, 32'h0001_0000, 32'h0);
        send_cmd(ddws_pkg::FUNC_TURN,    32'h7fff_ffff, 32'h0);
        send_cmd(ddws_pkg::FUNC_TURN,    32'hffff_ffff, 32'h0);
        send_cmd(ddws_pkg::FUNC_ARC,     32'h0001_0000, 32'd6553);
        send_cmd(ddws_pkg::FUNC_ARC,     32'h0001_0000, 32'd6554);
        send_cmd(ddws_pkg::FUNC_ARC,     32'hffff_0000, -32'sd6554);
        send_cmd(ddws_pkg::FUNC_ARC,     32'h0002_0000, 32'd655360);
        send_cmd(ddws_pkg::FUNC_ARC,     32'h0002_0000, 32'd655361);
        send_cmd(ddws_pkg::FUNC_ARC,     32'h0001_0000, -32'sd655361);
        send_cmd(ddws_pkg::FUNC_ARC,     32'h0001_0000, 32'h0);
        send_cmd(ddws_pkg::FUNC_ARC,     32'h8000_0000, 32'h8000_0000);
        send_cmd(ddws_pkg::FUNC_HEADING, 32'h0000_8000, 32'h7fff_ffff);
        send_cmd(ddws_pkg::FUNC_HEADING, 32'h8000_0000, 32'h8000_0000);
        send_cmd(ddws_pkg::FUNC_HEADING, 32'h0, 32'hffff_ffff);
        send_cmd(ddws_pkg::FUNC_ANGVEL,  32'h0001_0000, 32'h0001_0000);
        send_cmd(ddws_pkg::FUNC_ANGVEL,  32'h7fff_ffff, 32'h7fff_ffff);
        send_cmd(ddws_pkg::FUNC_ANGVEL,  32'h0, 32'h8000_0000);
        send_cmd(ddws_pkg::FUNC_STOP,    32'h7fff_ffff, 32'h7fff_ffff);
        send_cmd(3'd6,                   32'h1234_5678, 32'h0);
        send_cmd(3'd7,                   32'h8000_0000, 32'h8000_0000);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: begin
                    reg_write(ddws_pkg::REG_RADIUS, 32'd655);
                    reg_write(ddws_pkg::REG_TRACK,  32'd196608);
                end
                2: begin
                    reg_write(ddws_pkg::REG_RADIUS, 32'd65536);
                    reg_write(ddws_pkg::REG_TRACK,  32'd655);
                end
                3: begin
                    // zero radius behaves as one LSB
                    reg_write(ddws_pkg::REG_RADIUS, 32'd0);
                    reg_write(ddws_pkg::REG_TRACK,  32'h3ffff);
                end
                4: begin
                    reg_write(ddws_pkg::REG_RADIUS, 32'h1ffff);
                    reg_write(ddws_pkg::REG_TRACK,  32'd0);
                end
                5: begin
                    reg_write(ddws_pkg::REG_RADIUS, $urandom_range(655, 65536));
                    reg_write(ddws_pkg::REG_TRACK,  $urandom_range(655, 196608));
                    quiet = 1'b1;
                end
                default: ;
            endcase
            repeat (PER_PHASE) send_random();
            drain();
        end

        $display("%0d commands sent over 6 geometry settings; %0d results checked",
                 sent, checked);
        $display("%0d arc fallbacks and %0d saturated results seen", fallbacks, clipped);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
